[sv/button_short_long_press_classifier_unit_defines.svh]
// ---------------------------------------------------------------------------
// Button press classifier assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ---------------------------------------------------------------------------
`ifndef BUTTON_SHORT_LONG_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_SHORT_LONG_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BSLP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bslp assertion failed");

// Next-cycle implication.
`define BSLP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bslp assertion failed");

`endif

[sv/bslp_pkg.sv]
// ---------------------------------------------------------------------------
// Button press classifier package
// Payload structs, register indexes and reset values shared by all modules.
// ---------------------------------------------------------------------------
package bslp_pkg;

    localparam int TIMER_W   = 16;
    localparam int BTN_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIMER_W-1:0] DEBOUNCE_RST = 16'd10;
    localparam logic [TIMER_W-1:0] SHORT_RST    = 16'd250;
    localparam logic [TIMER_W-1:0] LONG_RST     = 16'd3000;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd2;

    typedef struct packed {
        logic             tick;
        logic [BTN_W-1:0] buttons;
    } in_t;

    typedef struct packed {
        logic [BTN_W-1:0] short_press;
        logic [BTN_W-1:0] long_press;
    } out_t;

    typedef struct packed {
        logic [TIMER_W-1:0] debounce_ticks;
        logic [TIMER_W-1:0] short_ticks;
        logic [TIMER_W-1:0] long_ticks;
    } cfg_t;

    typedef struct packed {
        logic short_hit;
        logic long_hit;
    } lane_evt_t;

endpackage

[sv/button_short_long_press_classifier_unit.sv]
// The result is registered in the output register and valid in the cycle after the input transfer.
// Throughput: one item per cycle unless the output register stalls; every button lane steps in the same cycle.
// A new item is taken whenever the output register is empty or being drained.
// Reset (rst_n low, asynchronous): all buttons idle, timers zero, registers
// return to debounce 10, short 250, long 3000 ticks; no result pending.
// ---------------------------------------------------------------------------
// Button short/long press classifier
// Parallel per-button lanes with a merge stage and a register write port.
// ---------------------------------------------------------------------------
`include "button_short_long_press_classifier_unit_defines.svh"

module button_short_long_press_classifier_unit
#(
    parameter int NUM_BUTTONS = 5
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bslp_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bslp_pkg::out_t                    out_data,
    input  logic                              cfg_we,
    input  logic [bslp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bslp_pkg::TIMER_W-1:0]      cfg_data
);

    bslp_pkg::cfg_t       cfg_reg;
    bslp_pkg::lane_evt_t  evt [NUM_BUTTONS];
    logic                 advance;

    // Accept while the output register is free or draining
    assign in_ready = !out_valid || out_ready;
    assign advance  = in_valid && in_ready;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= bslp_pkg::DEBOUNCE_RST;
            cfg_reg.short_ticks    <= bslp_pkg::SHORT_RST;
            cfg_reg.long_ticks     <= bslp_pkg::LONG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bslp_pkg::REG_DEBOUNCE: cfg_reg.debounce_ticks <= cfg_data;
                bslp_pkg::REG_SHORT:    cfg_reg.short_ticks    <= cfg_data;
                bslp_pkg::REG_LONG:     cfg_reg.long_ticks     <= cfg_data;
                default: ;
            endcase
        end
    end

    // One lane per button; buttons past the input field read released
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        logic pressed;
        if (i < bslp_pkg::BTN_W)
        begin : g_in
            assign pressed = in_data.buttons[i];
        end
        else
        begin : g_off
            assign pressed = 1'b0;
        end

        bslp_lane u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tick    (in_data.tick),
            .pressed (pressed),
            .cfg     (cfg_reg),
            .evt     (evt[i])
        );
    end

    // Combine lane pulses into the result register
    bslp_merge #(.NUM_BUTTONS(NUM_BUTTONS)) u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .evt       (evt),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // A button never reports short and long in the same result
    `BSLP_ASSERT_IMP(a_no_dual_pulse, out_valid, (out_data.short_press & out_data.long_press) == '0)
    // Every input transfer leaves a result pending
    `BSLP_ASSERT_NXT(a_result_follows, advance, out_valid)
    // A stalled result blocks new input
    `BSLP_ASSERT_IMP(a_stall_blocks, out_valid && !out_ready, !in_ready)

endmodule

[sv/bslp_lane.sv]
// ---------------------------------------------------------------------------
// Button press classifier lane
// Per-button timers and four-phase machine; steps once per transfer.
// ---------------------------------------------------------------------------
module bslp_lane
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 tick,
    input  logic                 pressed,
    input  bslp_pkg::cfg_t       cfg,
    output bslp_pkg::lane_evt_t  evt
);

    typedef enum logic [1:0]
    {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_SHORT    = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [bslp_pkg::TIMER_W-1:0]  deb_reg, deb_next, deb_dec;
    logic [bslp_pkg::TIMER_W-1:0]  sht_reg, sht_next, sht_dec;
    logic [bslp_pkg::TIMER_W-1:0]  lng_reg, lng_next, lng_dec;

    // Count down on a tick, stop at zero
    assign deb_dec = (tick && deb_reg != '0) ? deb_reg - 1'b1 : deb_reg;
    assign sht_dec = (tick && sht_reg != '0) ? sht_reg - 1'b1 : sht_reg;
    assign lng_dec = (tick && lng_reg != '0) ? lng_reg - 1'b1 : lng_reg;

    // Step the phase machine on the counted-down timers
    always_comb
    begin
        phase_next    = phase_reg;
        deb_next      = deb_dec;
        sht_next      = sht_dec;
        lng_next      = lng_dec;
        evt.short_hit = 1'b0;
        evt.long_hit  = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    deb_next   = cfg.debounce_ticks;
                    sht_next   = cfg.short_ticks;
                    lng_next   = cfg.long_ticks;
                    phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                if (deb_dec == '0)
                begin
                    phase_next = pressed ? PH_SHORT : PH_IDLE;
                end
            end
            PH_SHORT:
            begin
                if (sht_dec == '0)
                begin
                    if (pressed)
                    begin
                        phase_next = PH_LONG;
                    end
                    else
                    begin
                        evt.short_hit = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                end
            end
            PH_LONG:
            begin
                if (!pressed)
                begin
                    evt.long_hit  = (lng_dec == '0);
                    evt.short_hit = (lng_dec != '0);
                    phase_next    = PH_IDLE;
                end
            end
        endcase
    end

    // Hold state between transfers, advance on each one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            deb_reg   <= '0;
            sht_reg   <= '0;
            lng_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            deb_reg   <= deb_next;
            sht_reg   <= sht_next;
            lng_reg   <= lng_next;
        end
    end

endmodule

[sv/bslp_merge.sv]
// ---------------------------------------------------------------------------
// Button press classifier merge stage
// Gathers lane pulses into one result and holds it in the output register.
// ---------------------------------------------------------------------------
module bslp_merge
#(
    parameter int NUM_BUTTONS = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  bslp_pkg::lane_evt_t  evt [NUM_BUTTONS],
    input  logic                 out_ready,
    output logic                 out_valid,
    output bslp_pkg::out_t       out_data
);

    logic [bslp_pkg::BTN_W-1:0] sp_w;
    logic [bslp_pkg::BTN_W-1:0] lp_w;
    logic                       out_valid_reg;
    bslp_pkg::out_t             out_data_reg;

    // Map lanes onto field bits; lanes past the field width drop out
    for (genvar j = 0; j < bslp_pkg::BTN_W; j++)
    begin : g_bit
        if (j < NUM_BUTTONS)
        begin : g_lane
            assign sp_w[j] = evt[j].short_hit;
            assign lp_w[j] = evt[j].long_hit;
        end
        else
        begin : g_none
            assign sp_w[j] = 1'b0;
            assign lp_w[j] = 1'b0;
        end
    end

    // Load on each input transfer, drop valid once the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.short_press <= sp_w;
            out_data_reg.long_press  <= lp_w;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button short/long press classifier testbench
// Drives tick/button samples through the valid/ready input channel, predicts
// every short and long press pulse with a cycle-free model of the five
// button lanes, and compares each output transfer in order. A directed
// table covers reset, zero timer settings and the ignored register
// index; random phases then replay realistic press/release runs
// with bounces and noise under several timer settings and random idling.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int NBTN     = bslp_pkg::BTN_W;
    localparam int TW       = bslp_pkg::TIMER_W;
    localparam int IW       = bslp_pkg::CFG_IDX_W;
    localparam int LIMIT_NS = 4_000_000;

    // Unused register index; writes to it must have no effect.
    localparam logic [IW-1:0] REG_NONE = 2'd3;

    typedef enum logic [1:0] {
        BTN_IDLE       = 2'd0,
        BTN_DEBOUNCE   = 2'd1,
        BTN_SHORT_WAIT = 2'd2,
        BTN_LONG_WAIT  = 2'd3
    } press_phase_e;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [IW-1:0]          idx;
        logic [TW-1:0]          val;
        bslp_pkg::in_t          sample;
        logic                   typed;
        bslp_pkg::out_t         want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    bslp_pkg::in_t         in_data;
    logic                  out_valid;
    logic                  out_ready;
    bslp_pkg::out_t        out_data;
    logic                  cfg_we;
    logic [IW-1:0]         cfg_index;
    logic [TW-1:0]         cfg_data;

    // Press model state
    bslp_pkg::cfg_t        timer_cfg;
    press_phase_e          btn_phase [NBTN];
    logic [TW-1:0]         deb_left  [NBTN];
    logic [TW-1:0]         short_left[NBTN];
    logic [TW-1:0]         long_left [NBTN];

    bslp_pkg::out_t        pulse_q[$];
    dir_row_t              dir_rows[$];
    int                    mismatches;

    // Random sample generator state
    logic [NBTN-1:0]       gen_level;
    int                    gen_run [NBTN];
    int                    tick_pct;
    int                    send_calm;
    int                    recv_calm;

    button_short_long_press_classifier_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Timeout
    initial
    begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [TW-1:0] count_down(input logic [TW-1:0] t);
        return (t != '0) ? t - 1'b1 : '0;
    endfunction

    // Step all button lanes once and return the pulses this sample causes.
    function automatic bslp_pkg::out_t press_pulses(input bslp_pkg::in_t s);
        bslp_pkg::out_t r;
        logic pressed;
        r = '0;
        for (int i = 0; i < NBTN; i++)
        begin
            pressed = s.buttons[i];
            if (s.tick)
            begin
                deb_left[i]   = count_down(deb_left[i]);
                short_left[i] = count_down(short_left[i]);
                long_left[i]  = count_down(long_left[i]);
            end
            case (btn_phase[i])
                BTN_IDLE:
                begin
                    if (pressed)
                    begin
                        deb_left[i]   = timer_cfg.debounce_ticks;
                        short_left[i] = timer_cfg.short_ticks;
                        long_left[i]  = timer_cfg.long_ticks;
                        btn_phase[i]  = BTN_DEBOUNCE;
                    end
                end
                BTN_DEBOUNCE:
                begin
                    if (deb_left[i] == '0)
                    begin
                        if (pressed)
                            btn_phase[i] = BTN_SHORT_WAIT;
                        else
                            btn_phase[i] = BTN_IDLE;
                    end
                end
                BTN_SHORT_WAIT:
                begin
                    if (short_left[i] == '0)
                    begin
                        if (pressed)
                            btn_phase[i] = BTN_LONG_WAIT;
                        else
                        begin
                            r.short_press[i] = 1'b1;
                            btn_phase[i]     = BTN_IDLE;
                        end
                    end
                end
                default:
                begin
                    if (!pressed)
                    begin
                        if (long_left[i] == '0)
                            r.long_press[i] = 1'b1;
                        else
                            r.short_press[i] = 1'b1;
                        btn_phase[i] = BTN_IDLE;
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [NBTN-1:0] got,
                          input logic [NBTN-1:0] want);
        $display("mismatch: %s got %b want %b", what, got, want);
        mismatches++;
    endtask

    // Check each output transfer against the oldest pending pulse word.
    always @(posedge clk)
    begin
        bslp_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pulse_q.size() == 0)
                report("unexpected result", out_data.short_press, '0);
            else
            begin
                want = pulse_q.pop_front();
                if (out_data.short_press !== want.short_press)
                    report("short_press", out_data.short_press, want.short_press);
                if (out_data.long_press !== want.long_press)
                    report("long_press", out_data.long_press, want.long_press);
            end
        end
    end

    // Output side: stall a random number of cycles before each transfer.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (recv_calm > 0)
            begin
                recv_calm--;
                stall = 0;
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    recv_calm = $urandom_range(10, 40);
                stall = $urandom_range(0, 14);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Send one sample, hold it until transfer, then record its expected pulses.
    task automatic send_sample(input bslp_pkg::in_t s, input logic typed,
                               input bslp_pkg::out_t want);
        int gap;
        bslp_pkg::out_t p;
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 24) == 0)
                send_calm = $urandom_range(10, 40);
            gap = $urandom_range(0, 14);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
        p = press_pulses(s);
        pulse_q.push_back(typed ? want : p);
    endtask

    // Let the block go idle, then write one register.
    task automatic write_reg(input logic [IW-1:0] idx, input logic [TW-1:0] val);
        in_valid <= 1'b0;
        while (pulse_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bslp_pkg::REG_DEBOUNCE: timer_cfg.debounce_ticks = val;
            bslp_pkg::REG_SHORT:    timer_cfg.short_ticks    = val;
            bslp_pkg::REG_LONG:     timer_cfg.long_ticks     = val;
            default:      ;
        endcase
    endtask

    task automatic set_timers(input int deb, input int sht, input int lng);
        write_reg(bslp_pkg::REG_DEBOUNCE, deb[TW-1:0]);
        write_reg(bslp_pkg::REG_SHORT, sht[TW-1:0]);
        write_reg(bslp_pkg::REG_LONG, lng[TW-1:0]);
    endtask

    task automatic row_item(input logic tick, input logic [NBTN-1:0] btns,
                            input logic typed, input logic [NBTN-1:0] ws,
                            input logic [NBTN-1:0] wl);
        dir_row_t r;
        r = '0;
        r.kind           = ROW_ITEM;
        r.sample.tick    = tick;
        r.sample.buttons = btns;
        r.typed          = typed;
        r.want.short_press = ws;
        r.want.long_press  = wl;
        dir_rows.push_back(r);
    endtask

    task automatic row_cfg(input logic [IW-1:0] idx, input logic [TW-1:0] val);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        dir_rows.push_back(r);
    endtask

    // Next random sample: per-button press/release runs, bounces and noise.
    task automatic next_sample(output bslp_pkg::in_t s);
        int span;
        span = (int'(timer_cfg.debounce_ticks) + int'(timer_cfg.long_ticks) + 4) * 100
               / tick_pct;
        if (span > 300)
            span = 300;
        for (int i = 0; i < NBTN; i++)
        begin
            if (gen_run[i] <= 0)
            begin
                gen_level[i] = ~gen_level[i];
                if (!gen_level[i])
                    gen_run[i] = $urandom_range(1, 12);
                else if ($urandom_range(0, 4) == 0)
                    gen_run[i] = $urandom_range(1, int'(timer_cfg.debounce_ticks) + 1);
                else
                    gen_run[i] = $urandom_range(1, span);
            end
            gen_run[i]--;
        end
        s.tick = ($urandom_range(1, 100) <= tick_pct);
        if ($urandom_range(0, 6) == 0)
            s.buttons = NBTN'($urandom_range(0, 31));
        else
            s.buttons = gen_level;
    endtask

    initial
    begin
        bslp_pkg::in_t  s;
        int   n_items;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        send_calm  = 0;
        recv_calm  = 0;
        gen_level  = '0;
        tick_pct   = 100;
        timer_cfg.debounce_ticks = bslp_pkg::DEBOUNCE_RST;
        timer_cfg.short_ticks    = bslp_pkg::SHORT_RST;
        timer_cfg.long_ticks     = bslp_pkg::LONG_RST;
        for (int i = 0; i < NBTN; i++)
        begin
            btn_phase[i]  = BTN_IDLE;
            deb_left[i]   = '0;
            short_left[i] = '0;
            long_left[i]  = '0;
            gen_run[i]    = 0;
        end

        // Directed table: reset state, zero timers, bounce, ignored index,
        // short and long presses with short timers.
        row_item(1'b0, 5'b00000, 1'b1, 5'b00000, 5'b00000);
        row_item(1'b1, 5'b00000, 1'b1, 5'b00000, 5'b00000);
        row_cfg(bslp_pkg::REG_DEBOUNCE, 16'd0);
        row_cfg(bslp_pkg::REG_SHORT, 16'd0);
        row_cfg(bslp_pkg::REG_LONG, 16'd0);
        row_cfg(REG_NONE, 16'hFFFF);
        row_item(1'b0, 5'b11111, 1'b1, 5'b00000, 5'b00000);
        row_item(1'b0, 5'b11111, 1'b1, 5'b00000, 5'b00000);
        row_item(1'b0, 5'b11111, 1'b1, 5'b00000, 5'b00000);
        row_item(1'b0, 5'b00000, 1'b1, 5'b00000, 5'b11111);
        row_item(1'b0, 5'b10101, 1'b1, 5'b00000, 5'b00000);
        row_item(1'b0, 5'b10101, 1'b1, 5'b00000, 5'b00000);
        row_item(1'b0, 5'b00000, 1'b1, 5'b10101, 5'b00000);
        row_item(1'b0, 5'b00001, 1'b1, 5'b00000, 5'b00000);
        row_item(1'b0, 5'b00000, 1'b1, 5'b00000, 5'b00000);
        row_cfg(bslp_pkg::REG_DEBOUNCE, 16'd1);
        row_cfg(bslp_pkg::REG_SHORT, 16'd2);
        row_cfg(bslp_pkg::REG_LONG, 16'd4);
        row_item(1'b1, 5'b11111, 1'b0, '0, '0);
        row_item(1'b1, 5'b11111, 1'b0, '0, '0);
        row_item(1'b1, 5'b11111, 1'b0, '0, '0);
        row_item(1'b0, 5'b11100, 1'b0, '0, '0);
        row_item(1'b1, 5'b11100, 1'b0, '0, '0);
        row_item(1'b1, 5'b11100, 1'b0, '0, '0);
        row_item(1'b0, 5'b00000, 1'b0, '0, '0);
        row_item(1'b1, 5'b01010, 1'b0, '0, '0);
        row_item(1'b0, 5'b00000, 1'b0, '0, '0);

        // Hold reset, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_CFG)
                write_reg(dir_rows[k].idx, dir_rows[k].val);
            else
                send_sample(dir_rows[k].sample, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random phases; huge short or debounce timers only in the last one,
        // since they would trap lanes for tens of thousands of ticks.
        for (int ph = 0; ph < 8; ph++)
        begin
            n_items = 70;
            case (ph)
                0: set_timers(1, 1, 1);
                1: set_timers(0, 0, 0);
                2: set_timers($urandom_range(1, 4), $urandom_range(1, 15), $urandom_range(1, 40));
                3: set_timers($urandom_range(0, 6), $urandom_range(0, 20), $urandom_range(0, 60));
                4: set_timers($urandom_range(1, 3), $urandom_range(2, 8), $urandom_range(10, 30));
                5: set_timers(1, 3, 65535);
                6: set_timers($urandom_range(1, 5), $urandom_range(1, 30), $urandom_range(1, 30));
                default:
                begin
                    set_timers(65535, 65535, 65535);
                    n_items = 25;
                end
            endcase
            tick_pct = $urandom_range(30, 100);
            for (int n = 0; n < n_items; n++)
            begin
                next_sample(s);
                send_sample(s, 1'b0, '0);
            end
        end

        // Drain
        in_valid <= 1'b0;
        while (pulse_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
